FILE: rtl/core/barometer_pressure_compensation_defines.svh
// -----------------------------------------------------------------------------
// Barometer pressure compensation assertion macros
// Clocked concurrent checks shared by the pipeline modules.
// -----------------------------------------------------------------------------
`ifndef BAROMETER_PRESSURE_COMPENSATION_DEFINES_SVH
`define BAROMETER_PRESSURE_COMPENSATION_DEFINES_SVH

// check a property on every clock edge outside reset
`define BPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// check a property on every clock edge, reset included
`define BPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error(msg);

`endif

FILE: rtl/core/bpc_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Barometer pressure compensation package
// Payload types, coefficient bank, register indexes and scaling constants.
// -----------------------------------------------------------------------------
package bpc_pkg;

  localparam int RawW     = 10;
  localparam int CoefW    = 16;
  localparam int PresW    = 11;
  localparam int CfgIdxW  = 3;
  localparam int PolyW    = 31;
  localparam int DivShift = 13;
  localparam int MagW     = PolyW - DivShift;
  localparam int ScaleW   = 10;
  localparam int ProdW    = MagW + ScaleW;
  localparam int RecipW   = 30;
  localparam int RecipShift = 39;
  localparam int QuotW    = ProdW + RecipW - RecipShift;
  localparam int ValW     = QuotW + 2;

  localparam logic [ScaleW-1:0] ScaleMul  = ScaleW'(650);
  // ceil(2^39 / 1023): exact floor quotient for every product below 2^29
  localparam logic [RecipW-1:0] RecipDiv  = RecipW'(537395713);
  localparam logic [ValW-1:0]   ScaleOffs = ValW'(500);
  localparam logic [PresW-1:0]  PresMax   = {PresW{1'b1}};
  localparam logic [PresW-1:0]  PresMin   = '0;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_A0  = 3'd0,
    CFG_B1  = 3'd1,
    CFG_B2  = 3'd2,
    CFG_C12 = 3'd3,
    CFG_C11 = 3'd4,
    CFG_C22 = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [RawW-1:0] raw_pressure;
    logic [RawW-1:0] raw_temperature;
  } in_req_t;

  typedef struct packed {
    logic [PresW-1:0] pressure_tenth_kpa;
    logic             out_of_range;
  } out_res_t;

  typedef struct packed {
    logic signed [CoefW-1:0] a0;
    logic signed [CoefW-1:0] b1;
    logic signed [CoefW-1:0] b2;
    logic signed [CoefW-1:0] c12;
    logic signed [CoefW-1:0] c11;
    logic signed [CoefW-1:0] c22;
  } coef_t;

  typedef struct packed {
    logic                    valid;
    logic signed [PolyW-1:0] p;
  } poly_res_t;

endpackage

FILE: rtl/core/bpc_poly.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Compensation polynomial
// Four stages: coefficient products, shifted sums, raw products, final sum.
// -----------------------------------------------------------------------------
`include "barometer_pressure_compensation_defines.svh"

module bpc_poly (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                in_valid_i,
  input  bpc_pkg::in_req_t    in_req_i,
  input  bpc_pkg::coef_t      coef_i,
  output bpc_pkg::poly_res_t  poly_o
);

  localparam int RawW  = bpc_pkg::RawW;
  localparam int CoefW = bpc_pkg::CoefW;

  logic [3:0] vld_q;

  logic [RawW-1:0] pad1_q, tad1_q, pad2_q, tad2_q;

  logic signed [CoefW+RawW:0]   p11_d, p12_d, p22_d;
  logic signed [CoefW+RawW:0]   p11_q, p12_q, p22_q;
  logic signed [30:0]           s11;
  logic signed [16:0]           a11;
  logic signed [28:0]           s1;
  logic signed [31:0]           s2;
  logic signed [17:0]           a1_d, a1_q;
  logic signed [15:0]           a2_d, a2_q;
  logic signed [28:0]           a1x1_d, a1x1_q;
  logic signed [26:0]           a2x2_d, a2x2_q;
  logic signed [29:0]           s3;
  logic signed [19:0]           y1;
  logic signed [30:0]           p_d, p_q;

  always_comb begin
    p11_d = coef_i.c11 * $signed({1'b0, in_req_i.raw_pressure});
    p12_d = coef_i.c12 * $signed({1'b0, in_req_i.raw_temperature});
    p22_d = coef_i.c22 * $signed({1'b0, in_req_i.raw_temperature});

    s11  = $signed({coef_i.b1, 14'd0}) + 31'(p11_q);
    a11  = s11[30:14];
    s1   = $signed({a11, 11'd0}) + 29'(p12_q);
    a1_d = s1[28:11];
    s2   = $signed({coef_i.b2, 15'd0}) + 32'(p22_q >>> 1);
    a2_d = s2[31:16];

    a1x1_d = a1_q * $signed({1'b0, pad2_q});
    a2x2_d = a2_q * $signed({1'b0, tad2_q});

    s3  = $signed({coef_i.a0, 10'd0}) + 30'(a1x1_q);
    y1  = s3[29:10];
    p_d = $signed({y1, 10'd0}) + 31'(a2x2_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pad1_q <= in_req_i.raw_pressure;
      tad1_q <= in_req_i.raw_temperature;
      p11_q  <= p11_d;
      p12_q  <= p12_d;
      p22_q  <= p22_d;
      pad2_q <= pad1_q;
      tad2_q <= tad1_q;
      a1_q   <= a1_d;
      a2_q   <= a2_d;
      a1x1_q <= a1x1_d;
      a2x2_q <= a2x2_d;
      p_q    <= p_d;
    end
  end

  assign poly_o.valid = vld_q[3];
  assign poly_o.p     = p_q;

  `BPC_ASSERT(a_poly_hold, !adv_i |=> $stable(vld_q), "poly valid bits moved during stall")
  `BPC_ASSERT(a_poly_shift, adv_i |=> (vld_q[0] == $past(in_valid_i)),
              "poly stage 1 valid lost")
  `BPC_ASSERT(a_poly_advance, adv_i |=> (vld_q[3:1] == $past(vld_q[2:0])),
              "poly valid bits did not advance")

endmodule

FILE: rtl/core/bpc_scale.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Pressure scaling
// Four stages: truncating divide by 8192, scale by 650, reciprocal divide by
// 1023, offset and saturation into the output register.
// -----------------------------------------------------------------------------
`include "barometer_pressure_compensation_defines.svh"

module bpc_scale (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  bpc_pkg::poly_res_t  poly_i,
  output logic                out_valid_o,
  output bpc_pkg::out_res_t   out_res_o
);

  localparam int PolyW  = bpc_pkg::PolyW;
  localparam int MagW   = bpc_pkg::MagW;
  localparam int ProdW  = bpc_pkg::ProdW;
  localparam int RecipW = bpc_pkg::RecipW;
  localparam int QuotW  = bpc_pkg::QuotW;
  localparam int ValW   = bpc_pkg::ValW;
  localparam int PresW  = bpc_pkg::PresW;

  logic [2:0] vld_q;
  logic       vld_out_q;

  logic                      neg5_q, neg6_q, neg7_q;
  logic [PolyW-1:0]          pabs;
  logic [MagW-1:0]           mag_d, mag_q;
  logic [ProdW-1:0]          m_d, m_q;
  logic [ProdW+RecipW-1:0]   recip_prod;
  logic [QuotW-1:0]          quot_d, quot_q;
  logic signed [ValW-1:0]    val;
  bpc_pkg::out_res_t         res_d, res_q;

  always_comb begin
    pabs   = poly_i.p[PolyW-1] ? PolyW'(-poly_i.p) : PolyW'(poly_i.p);
    mag_d  = pabs[PolyW-1:bpc_pkg::DivShift];
    m_d    = ProdW'(mag_q * bpc_pkg::ScaleMul);
    recip_prod = m_q * bpc_pkg::RecipDiv;
    quot_d = recip_prod[ProdW+RecipW-1:bpc_pkg::RecipShift];

    if (neg7_q) begin
      val = $signed(bpc_pkg::ScaleOffs) - $signed(ValW'(quot_q));
    end else begin
      val = $signed(bpc_pkg::ScaleOffs) + $signed(ValW'(quot_q));
    end

    priority if (val < 0) begin
      res_d.pressure_tenth_kpa = bpc_pkg::PresMin;
      res_d.out_of_range       = 1'b1;
    end else if (val > $signed(ValW'(bpc_pkg::PresMax))) begin
      res_d.pressure_tenth_kpa = bpc_pkg::PresMax;
      res_d.out_of_range       = 1'b1;
    end else begin
      res_d.pressure_tenth_kpa = val[PresW-1:0];
      res_d.out_of_range       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      vld_out_q <= 1'b0;
    end else if (adv_i) begin
      vld_q     <= {vld_q[1:0], poly_i.valid};
      vld_out_q <= vld_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      neg5_q <= poly_i.p[PolyW-1];
      mag_q  <= mag_d;
      neg6_q <= neg5_q;
      m_q    <= m_d;
      neg7_q <= neg6_q;
      quot_q <= quot_d;
      res_q  <= res_d;
    end
  end

  assign out_valid_o = vld_out_q;
  assign out_res_o   = res_q;

  `BPC_ASSERT(a_scale_sat,
              out_valid_o && out_res_o.out_of_range |->
              (out_res_o.pressure_tenth_kpa == bpc_pkg::PresMax ||
               out_res_o.pressure_tenth_kpa == bpc_pkg::PresMin),
              "out of range result not saturated")
  `BPC_ASSERT(a_scale_hold, !adv_i |=> $stable({vld_q, vld_out_q}),
              "scale valid bits moved during stall")

endmodule

FILE: rtl/core/barometer_pressure_compensation.sv
// Each accepted request reaches the output through the eight registered stages.
// Throughput: one request per cycle; the eight stages advance together and
// freeze while a finished result waits on out_stall_i.
// Reset clears all stage valid bits and sets the six coefficients to zero.
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Barometer pressure compensation
// Coefficient registers, pipeline advance control and the two datapath halves.
// -----------------------------------------------------------------------------
`include "barometer_pressure_compensation_defines.svh"

module barometer_pressure_compensation (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bpc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [bpc_pkg::CoefW-1:0]       cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  bpc_pkg::in_req_t                in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output bpc_pkg::out_res_t               out_res_o
);

  bpc_pkg::coef_t     coef_q;
  bpc_pkg::poly_res_t poly;
  logic               adv;

  // hold every stage while the output register cannot drain
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (cfg_we_i) begin
      unique case (bpc_pkg::cfg_idx_e'(cfg_idx_i))
        bpc_pkg::CFG_A0:  coef_q.a0  <= $signed(cfg_wdata_i);
        bpc_pkg::CFG_B1:  coef_q.b1  <= $signed(cfg_wdata_i);
        bpc_pkg::CFG_B2:  coef_q.b2  <= $signed(cfg_wdata_i);
        bpc_pkg::CFG_C12: coef_q.c12 <= $signed(cfg_wdata_i);
        bpc_pkg::CFG_C11: coef_q.c11 <= $signed(cfg_wdata_i);
        bpc_pkg::CFG_C22: coef_q.c22 <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  bpc_poly u_poly (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (in_valid_i),
    .in_req_i   (in_req_i),
    .coef_i     (coef_q),
    .poly_o     (poly)
  );

  bpc_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .poly_i      (poly),
    .out_valid_o (out_valid_o),
    .out_res_o   (out_res_o)
  );

  `BPC_ASSERT(a_top_stall_cause, in_stall_o |-> out_valid_o && out_stall_i,
              "input stalled without a blocked result")
  `BPC_ASSERT(a_top_cfg_bad_idx,
              cfg_we_i && cfg_idx_i != bpc_pkg::CFG_A0 && cfg_idx_i != bpc_pkg::CFG_B1 &&
              cfg_idx_i != bpc_pkg::CFG_B2 && cfg_idx_i != bpc_pkg::CFG_C12 &&
              cfg_idx_i != bpc_pkg::CFG_C11 && cfg_idx_i != bpc_pkg::CFG_C22
              |=> $stable(coef_q),
              "write to unknown index changed a coefficient")

endmodule
